// ===== src/lrcf_pkg.sv =====
`default_nettype none
package lrcf_pkg;

  localparam int PANEL_WIDTH  = 240;
  localparam int PANEL_HEIGHT = 320;
  localparam int PANEL_MAX    = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int CRD_W        = $clog2(PANEL_MAX + 1);
  localparam int PROD_W       = 2 * CRD_W;

  localparam int CNT_W     = 17;
  localparam int COUNT_MAX = 131071;
  localparam int COL_W     = 16;
  localparam int VAL_W     = 16;
  localparam int POS_W     = 16;

  localparam int PANEL_AREA = PANEL_WIDTH * PANEL_HEIGHT;
  localparam logic [CNT_W-1:0] FULL_CNT =
    CNT_W'((PANEL_AREA > COUNT_MAX) ? COUNT_MAX : PANEL_AREA);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // command modes
  localparam logic [2:0] MODE_PIXEL  = 3'd0;
  localparam logic [2:0] MODE_HLINE  = 3'd1;
  localparam logic [2:0] MODE_VLINE  = 3'd2;
  localparam logic [2:0] MODE_RECT   = 3'd3;
  localparam logic [2:0] MODE_SCREEN = 3'd4;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // result kinds and register selects
  localparam logic KIND_REG  = 1'b0;
  localparam logic KIND_FILL = 1'b1;

  localparam logic [2:0] SEL_CUR_X = 3'd0;
  localparam logic [2:0] SEL_CUR_Y = 3'd1;
  localparam logic [2:0] SEL_X_STA = 3'd2;
  localparam logic [2:0] SEL_X_END = 3'd3;
  localparam logic [2:0] SEL_Y_STA = 3'd4;
  localparam logic [2:0] SEL_Y_END = 3'd5;
  localparam logic [2:0] SEL_DATA  = 3'd6;

  typedef enum logic [1:0] {
    CLS_PIXEL,
    CLS_SCREEN,
    CLS_RECT
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [1:0]       rot;
    logic [CRD_W-1:0] a1;
    logic [CRD_W-1:0] a2;
    logic [CRD_W-1:0] b1;
    logic [CRD_W-1:0] b2;
    logic [CRD_W-1:0] cx;
    logic [CRD_W-1:0] cy;
    logic [CNT_W-1:0] cnt;
    logic [COL_W-1:0] col;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // panel corner where the scan starts for a rotation
  function automatic logic [CRD_W-1:0] corner_x(input logic [1:0] rot);
    logic [CRD_W-1:0] v;
    v = (rot == ROT_90 || rot == ROT_180) ? CRD_W'(PANEL_WIDTH - 1) : '0;
    return v;
  endfunction

  function automatic logic [CRD_W-1:0] corner_y(input logic [1:0] rot);
    logic [CRD_W-1:0] v;
    v = (rot == ROT_180 || rot == ROT_270) ? CRD_W'(PANEL_HEIGHT - 1) : '0;
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [PROD_W-1:0] p);
    logic [CNT_W-1:0] v;
    if (32'(p) > COUNT_MAX) begin
      v = CNT_W'(COUNT_MAX);
    end else begin
      v = CNT_W'(p);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/lcd_rect_clip_rotate_fill.sv =====
`default_nettype none
// The first word of a command passes the clip register, queue, sequencer and output register.
// Throughput: one result word per cycle from the back sequencer; a line or rectangle
// yields 13 result words, a pixel or full screen 3, a clipped-away command none.
// A four-entry queue between clip front and sequencer keeps start open meanwhile, until it fills.
// Reset (rst_n low, synchronous): rotation to 0, queue and sequencer emptied, busy low.
module lcd_rect_clip_rotate_fill (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_mode,
  input  wire logic signed [15:0] in_x_pos,
  input  wire logic signed [15:0] in_y_pos,
  input  wire logic signed [15:0] in_span_w,
  input  wire logic signed [15:0] in_span_h,
  input  wire logic [15:0]        in_pixel_color,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata,
  output logic                    out_valid,
  output logic                    out_kind,
  output logic [2:0]              out_reg_sel,
  output logic [15:0]             out_reg_value,
  output logic [16:0]             out_fill_count,
  output logic [15:0]             out_fill_color,
  output logic                    out_last
);

  logic [1:0]         rotation_r;
  logic               q_push, q_pop;
  lrcf_pkg::entry_t   q_wr, q_rd;
  lrcf_pkg::q_stat_t  q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= lrcf_pkg::ROT_0;
    end else if (cfg_we) begin
      rotation_r <= cfg_wdata;
    end
  end

  lrcf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_span_w      (in_span_w),
    .in_span_h      (in_span_h),
    .in_pixel_color (in_pixel_color),
    .rotation       (rotation_r),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_entry        (q_wr)
  );

  lrcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .stat     (q_stat)
  );

  lrcf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rd_entry       (q_rd),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_reg_sel    (out_reg_sel),
    .out_reg_value  (out_reg_value),
    .out_fill_count (out_fill_count),
    .out_fill_color (out_fill_color),
    .out_last       (out_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty))
    else $error("queue read while empty");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == lrcf_pkg::KIND_FILL) |-> (out_fill_count != '0))
    else $error("fill run with zero pixels");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_last)
    else $error("last flag without a result word");

endmodule
`default_nettype wire

// ===== src/lrcf_front.sv =====
`default_nettype none
module lrcf_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   in_mode,
  input  wire logic signed [15:0]           in_x_pos,
  input  wire logic signed [15:0]           in_y_pos,
  input  wire logic signed [15:0]           in_span_w,
  input  wire logic signed [15:0]           in_span_h,
  input  wire logic [15:0]                  in_pixel_color,
  input  wire logic [1:0]                   rotation,
  input  wire lrcf_pkg::q_stat_t            q_stat,
  output logic                              q_push,
  output lrcf_pkg::entry_t                  q_entry
);

  localparam int CW = lrcf_pkg::CRD_W;
  localparam logic [CW-1:0] WM1 = CW'(lrcf_pkg::PANEL_WIDTH - 1);
  localparam logic [CW-1:0] HM1 = CW'(lrcf_pkg::PANEL_HEIGHT - 1);

  logic accept;

  logic signed [17:0] xs, ys, ws, hs, x2s, y2s, lws, lhs, lwm1, lhm1;
  logic               rej;
  lrcf_pkg::cls_t     cls;
  logic [CW-1:0]      x1c, y1c, x2c, y2c;

  logic                   a_valid_r, a_valid_nxt;
  lrcf_pkg::cls_t         a_cls_r;
  logic [1:0]             a_rot_r;
  logic [CW-1:0]          a_x1_r, a_y1_r, a_x2_r, a_y2_r;
  logic [15:0]            a_col_r;

  logic [CW-1:0]                  dx, dy;
  logic [lrcf_pkg::PROD_W-1:0]    prod;

  assign busy   = a_valid_r && q_stat.full;
  assign accept = start && !busy;
  assign q_push = a_valid_r && !q_stat.full;

  // clip stage: all arithmetic in 18 bits so nothing wraps
  always_comb begin
    xs  = {{2{in_x_pos[15]}}, in_x_pos};
    ys  = {{2{in_y_pos[15]}}, in_y_pos};
    ws  = {{2{in_span_w[15]}}, in_span_w};
    hs  = {{2{in_span_h[15]}}, in_span_h};
    cls = lrcf_pkg::CLS_RECT;
    case (in_mode)
      lrcf_pkg::MODE_PIXEL: begin
        ws  = 18'sd1;
        hs  = 18'sd1;
        cls = lrcf_pkg::CLS_PIXEL;
      end
      lrcf_pkg::MODE_HLINE:  hs = 18'sd1;
      lrcf_pkg::MODE_VLINE:  ws = 18'sd1;
      lrcf_pkg::MODE_RECT:   cls = lrcf_pkg::CLS_RECT;
      lrcf_pkg::MODE_SCREEN: cls = lrcf_pkg::CLS_SCREEN;
      default:               cls = lrcf_pkg::CLS_RECT;
    endcase
    lws  = rotation[0] ? 18'(lrcf_pkg::PANEL_HEIGHT) : 18'(lrcf_pkg::PANEL_WIDTH);
    lhs  = rotation[0] ? 18'(lrcf_pkg::PANEL_WIDTH) : 18'(lrcf_pkg::PANEL_HEIGHT);
    lwm1 = lws - 18'sd1;
    lhm1 = lhs - 18'sd1;
    x2s  = xs + ws - 18'sd1;
    y2s  = ys + hs - 18'sd1;
    rej  = (ws <= 18'sd0) || (hs <= 18'sd0) || (xs >= lws) || (ys >= lhs) ||
           (x2s < 18'sd0) || (y2s < 18'sd0);
    if (in_mode == lrcf_pkg::MODE_SCREEN) begin
      rej = 1'b0;
    end else if (in_mode > lrcf_pkg::MODE_SCREEN) begin
      rej = 1'b1;
    end
    x1c = (xs < 18'sd0) ? '0 : xs[CW-1:0];
    y1c = (ys < 18'sd0) ? '0 : ys[CW-1:0];
    x2c = (x2s >= lws) ? lwm1[CW-1:0] : x2s[CW-1:0];
    y2c = (y2s >= lhs) ? lhm1[CW-1:0] : y2s[CW-1:0];
  end

  // drop rejected words here so they never reach the queue
  always_comb begin
    a_valid_nxt = a_valid_r && !q_push;
    if (accept) begin
      a_valid_nxt = !rej;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cls_r <= cls;
      a_rot_r <= rotation;
      a_x1_r  <= x1c;
      a_y1_r  <= y1c;
      a_x2_r  <= x2c;
      a_y2_r  <= y2c;
      a_col_r <= in_pixel_color;
    end
  end

  // map stage: logical window to panel coordinates, pixel count
  always_comb begin
    dx   = a_x2_r - a_x1_r + CW'(1);
    dy   = a_y2_r - a_y1_r + CW'(1);
    prod = lrcf_pkg::PROD_W'(dx) * lrcf_pkg::PROD_W'(dy);

    q_entry     = '0;
    q_entry.cls = a_cls_r;
    q_entry.rot = a_rot_r;
    q_entry.col = a_col_r;
    q_entry.cnt = lrcf_pkg::sat_cnt(prod);
    case (a_rot_r)
      lrcf_pkg::ROT_90: begin
        q_entry.a1 = WM1 - a_y2_r;
        q_entry.a2 = WM1 - a_y1_r;
        q_entry.b1 = a_x1_r;
        q_entry.b2 = a_x2_r;
        q_entry.cx = WM1 - a_y1_r;
        q_entry.cy = a_x1_r;
      end
      lrcf_pkg::ROT_180: begin
        q_entry.a1 = WM1 - a_x2_r;
        q_entry.a2 = WM1 - a_x1_r;
        q_entry.b1 = HM1 - a_y2_r;
        q_entry.b2 = HM1 - a_y1_r;
        q_entry.cx = WM1 - a_x1_r;
        q_entry.cy = HM1 - a_y1_r;
      end
      lrcf_pkg::ROT_270: begin
        q_entry.a1 = a_y1_r;
        q_entry.a2 = a_y2_r;
        q_entry.b1 = HM1 - a_x2_r;
        q_entry.b2 = HM1 - a_x1_r;
        q_entry.cx = a_y1_r;
        q_entry.cy = HM1 - a_x1_r;
      end
      default: begin
        q_entry.a1 = a_x1_r;
        q_entry.a2 = a_x2_r;
        q_entry.b1 = a_y1_r;
        q_entry.b2 = a_y2_r;
        q_entry.cx = a_x1_r;
        q_entry.cy = a_y1_r;
      end
    endcase
    if (a_cls_r == lrcf_pkg::CLS_SCREEN) begin
      q_entry.cx  = lrcf_pkg::corner_x(a_rot_r);
      q_entry.cy  = lrcf_pkg::corner_y(a_rot_r);
      q_entry.cnt = lrcf_pkg::FULL_CNT;
    end
  end

endmodule
`default_nettype wire

// ===== src/lrcf_queue.sv =====
`default_nettype none
module lrcf_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire lrcf_pkg::entry_t   wr_entry,
  input  wire logic               pop,
  output lrcf_pkg::entry_t        rd_entry,
  output lrcf_pkg::q_stat_t       stat
);

  lrcf_pkg::entry_t mem_r [lrcf_pkg::QDEPTH];

  logic [lrcf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [lrcf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == lrcf_pkg::QCNT_W'(lrcf_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_entry   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == lrcf_pkg::QPTR_W'(lrcf_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + lrcf_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == lrcf_pkg::QPTR_W'(lrcf_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + lrcf_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + lrcf_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - lrcf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

// ===== src/lrcf_back.sv =====
`default_nettype none
module lrcf_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lrcf_pkg::entry_t   rd_entry,
  input  wire lrcf_pkg::q_stat_t  q_stat,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic                    out_kind,
  output logic [2:0]              out_reg_sel,
  output logic [15:0]             out_reg_value,
  output logic [16:0]             out_fill_count,
  output logic [15:0]             out_fill_color,
  output logic                    out_last
);

  // sequencer positions, window commands
  localparam logic [3:0] R_XS  = 4'd0;
  localparam logic [3:0] R_XE  = 4'd1;
  localparam logic [3:0] R_YS  = 4'd2;
  localparam logic [3:0] R_YE  = 4'd3;
  localparam logic [3:0] R_CX  = 4'd4;
  localparam logic [3:0] R_CY  = 4'd5;
  localparam logic [3:0] R_FL  = 4'd6;
  localparam logic [3:0] R_FXS = 4'd7;
  localparam logic [3:0] R_FXE = 4'd8;
  localparam logic [3:0] R_FYS = 4'd9;
  localparam logic [3:0] R_FYE = 4'd10;
  localparam logic [3:0] R_FCX = 4'd11;
  localparam logic [3:0] R_FCY = 4'd12;
  // sequencer positions, pixel and full screen
  localparam logic [3:0] S_CX  = 4'd0;
  localparam logic [3:0] S_CY  = 4'd1;
  localparam logic [3:0] S_FIN = 4'd2;

  localparam int CW = lrcf_pkg::CRD_W;

  logic               act_r, act_nxt;
  lrcf_pkg::entry_t   ent_r;
  logic [3:0]         step_r, step_nxt;
  logic               done, load;

  logic        kind_nxt, last_nxt;
  logic [2:0]  sel_nxt;
  logic [CW-1:0] crd;
  logic [15:0] val_nxt;
  logic [16:0] cnt_nxt;
  logic [15:0] col_nxt;

  logic        valid_r, kind_r, last_r;
  logic [2:0]  sel_r;
  logic [15:0] val_r, col_r;
  logic [16:0] cnt_r;

  assign done  = act_r && (step_r == ((ent_r.cls == lrcf_pkg::CLS_RECT) ? R_FCY : S_FIN));
  assign load  = !q_stat.empty && (!act_r || done);
  assign q_pop = load;

  always_comb begin
    act_nxt  = act_r && !done;
    step_nxt = act_r ? step_r + 4'd1 : step_r;
    if (load) begin
      act_nxt  = 1'b1;
      step_nxt = '0;
    end
  end

  // decode the word for the current step
  always_comb begin
    kind_nxt = lrcf_pkg::KIND_REG;
    sel_nxt  = lrcf_pkg::SEL_CUR_X;
    crd      = '0;
    cnt_nxt  = '0;
    col_nxt  = '0;
    last_nxt = done;
    if (ent_r.cls == lrcf_pkg::CLS_RECT) begin
      case (step_r)
        R_XS: begin sel_nxt = lrcf_pkg::SEL_X_STA; crd = ent_r.a1; end
        R_XE: begin sel_nxt = lrcf_pkg::SEL_X_END; crd = ent_r.a2; end
        R_YS: begin sel_nxt = lrcf_pkg::SEL_Y_STA; crd = ent_r.b1; end
        R_YE: begin sel_nxt = lrcf_pkg::SEL_Y_END; crd = ent_r.b2; end
        R_CX: begin sel_nxt = lrcf_pkg::SEL_CUR_X; crd = ent_r.cx; end
        R_CY: begin sel_nxt = lrcf_pkg::SEL_CUR_Y; crd = ent_r.cy; end
        R_FL: begin
          kind_nxt = lrcf_pkg::KIND_FILL;
          cnt_nxt  = ent_r.cnt;
          col_nxt  = ent_r.col;
        end
        R_FXS: sel_nxt = lrcf_pkg::SEL_X_STA;
        R_FXE: begin sel_nxt = lrcf_pkg::SEL_X_END; crd = CW'(lrcf_pkg::PANEL_WIDTH - 1); end
        R_FYS: sel_nxt = lrcf_pkg::SEL_Y_STA;
        R_FYE: begin sel_nxt = lrcf_pkg::SEL_Y_END; crd = CW'(lrcf_pkg::PANEL_HEIGHT - 1); end
        R_FCX: begin sel_nxt = lrcf_pkg::SEL_CUR_X; crd = lrcf_pkg::corner_x(ent_r.rot); end
        R_FCY: begin sel_nxt = lrcf_pkg::SEL_CUR_Y; crd = lrcf_pkg::corner_y(ent_r.rot); end
        default: sel_nxt = lrcf_pkg::SEL_CUR_X;
      endcase
    end else begin
      case (step_r)
        S_CX: begin sel_nxt = lrcf_pkg::SEL_CUR_X; crd = ent_r.cx; end
        S_CY: begin sel_nxt = lrcf_pkg::SEL_CUR_Y; crd = ent_r.cy; end
        S_FIN: begin
          if (ent_r.cls == lrcf_pkg::CLS_SCREEN) begin
            kind_nxt = lrcf_pkg::KIND_FILL;
            cnt_nxt  = ent_r.cnt;
            col_nxt  = ent_r.col;
          end else begin
            sel_nxt  = lrcf_pkg::SEL_DATA;
          end
        end
        default: sel_nxt = lrcf_pkg::SEL_CUR_X;
      endcase
    end
    val_nxt = 16'(crd);
    if (kind_nxt == lrcf_pkg::KIND_REG && sel_nxt == lrcf_pkg::SEL_DATA) begin
      val_nxt = ent_r.col;
    end
    if (!act_r) begin
      kind_nxt = lrcf_pkg::KIND_REG;
      sel_nxt  = lrcf_pkg::SEL_CUR_X;
      val_nxt  = '0;
      cnt_nxt  = '0;
      col_nxt  = '0;
      last_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      step_r  <= step_nxt;
      valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= rd_entry;
    end
    kind_r <= kind_nxt;
    sel_r  <= sel_nxt;
    val_r  <= val_nxt;
    cnt_r  <= cnt_nxt;
    col_r  <= col_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_reg_sel    = sel_r;
  assign out_reg_value  = val_r;
  assign out_fill_count = cnt_r;
  assign out_fill_color = col_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire
